### src/packed_group_dequant_dot_unit_defines.svh
// assertion macros for the packed group dequant dot unit
// used by the top level only; no other dependencies
`ifndef PACKED_GROUP_DEQUANT_DOT_UNIT_DEFINES_SVH
`define PACKED_GROUP_DEQUANT_DOT_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PGDD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("pgdd same-cycle check failed");

// next-cycle implication, disabled during reset
`define PGDD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("pgdd next-cycle check failed");

`endif

### src/pgdd_pkg.sv
// shared widths, constants and controller/datapath types
// no dependencies
`timescale 1ns / 1ps

package pgdd_pkg;

  localparam int unsigned ACT_W   = 16;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BUF_W   = 48;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned CODE_W  = 16;
  localparam int unsigned NB_W    = 5;
  localparam int unsigned QP_W    = 16;
  localparam int unsigned PROD_W  = CODE_W + 1 + QP_W;
  localparam int unsigned WGT_W   = PROD_W + 1;
  localparam int unsigned TERM_W  = ACT_W + WGT_W;
  localparam int unsigned ACC_W   = 64;

  localparam logic [NB_W-1:0]  CODE_BITS_RESET = NB_W'(4);
  localparam logic [NB_W-1:0]  CODE_BITS_MIN   = NB_W'(1);
  localparam logic [NB_W-1:0]  CODE_BITS_MAX   = NB_W'(CODE_W);
  localparam logic [CNT_W-1:0] APPEND_MAX_CNT  = CNT_W'(BUF_W - WORD_W);
  localparam logic [CNT_W-1:0] WORD_CNT        = CNT_W'(WORD_W);

  // one input item as it crosses from the top level into the datapath
  typedef struct packed {
    logic signed [ACT_W-1:0] act;
    logic [WORD_W-1:0]       packed_word;
    logic                    word_valid;
    logic                    group_start;
    logic signed [QP_W-1:0]  group_scale;
    logic signed [QP_W-1:0]  group_bias;
    logic                    last_of_row;
  } in_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic extract;
    logic mul;
    logic mac;
    logic acc;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             last;
    logic [CNT_W-1:0] bit_count;
  } status_t;

endpackage

### src/pgdd_if.sv
// valid/ready channel interfaces for items in and results out
// depends on pgdd_pkg
`timescale 1ns / 1ps

interface pgdd_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [pgdd_pkg::ACT_W-1:0] act;
  logic [pgdd_pkg::WORD_W-1:0]      packed_word;
  logic                             word_valid;
  logic                             group_start;
  logic signed [pgdd_pkg::QP_W-1:0] group_scale;
  logic signed [pgdd_pkg::QP_W-1:0] group_bias;
  logic                             last_of_row;

  modport source (
    output valid, act, packed_word, word_valid, group_start, group_scale, group_bias,
           last_of_row,
    input  ready
  );
  modport sink (
    input  valid, act, packed_word, word_valid, group_start, group_scale, group_bias,
           last_of_row,
    output ready
  );
endinterface

interface pgdd_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pgdd_pkg::ACC_W-1:0] dot_result;
  logic                              row_error;

  modport source (output valid, dot_result, row_error, input ready);
  modport sink (input valid, dot_result, row_error, output ready);
endinterface

### src/pgdd_ctrl.sv
// sequencing controller: one item at a time through extract, multiply, accumulate
// depends on pgdd_pkg
`timescale 1ns / 1ps

module pgdd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  pgdd_pkg::status_t status_i,
  output pgdd_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXTRACT,
    S_MUL,
    S_MAC,
    S_ACC
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q, in_ready_d;
  logic   out_valid_q, out_valid_d;
  logic   acc_go;

  // a row end waits while the result register still holds an untaken result
  assign acc_go = (state_q == S_ACC) &&
                  (!status_i.last || !out_valid_q || out_ready_i);

  // commands
  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = in_valid_i && in_ready_q;
    cmd_o.extract = (state_q == S_EXTRACT);
    cmd_o.mul     = (state_q == S_MUL);
    cmd_o.mac     = (state_q == S_MAC);
    cmd_o.acc     = acc_go;
    cmd_o.emit    = acc_go && status_i.last;
  end

  // next state and registered handshake outputs
  always_comb begin
    state_d     = state_q;
    in_ready_d  = in_ready_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_q) begin
          state_d    = S_EXTRACT;
          in_ready_d = 1'b0;
        end
      end
      S_EXTRACT: state_d = S_MUL;
      S_MUL:     state_d = S_MAC;
      S_MAC:     state_d = S_ACC;
      S_ACC: begin
        if (acc_go) begin
          state_d    = S_IDLE;
          in_ready_d = 1'b1;
          if (status_i.last) begin
            out_valid_d = 1'b1;
          end
        end
      end
      default: begin
        state_d    = S_IDLE;
        in_ready_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_ready_q  <= in_ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

### src/pgdd_datapath.sv
// bit buffer, group registers, two multiply stages, saturating accumulator
// depends on pgdd_pkg
`timescale 1ns / 1ps

module pgdd_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pgdd_pkg::NB_W-1:0]         cfg_wdata_i,
  input  pgdd_pkg::cmd_t                    cmd_i,
  input  pgdd_pkg::in_item_t                item_i,
  output pgdd_pkg::status_t                 status_o,
  output logic signed [pgdd_pkg::ACC_W-1:0] dot_result_o,
  output logic                              row_error_o
);

  logic [pgdd_pkg::NB_W-1:0]          code_bits_q;
  logic [pgdd_pkg::BUF_W-1:0]         buf_q, buf_d;
  logic [pgdd_pkg::CNT_W-1:0]         cnt_q, cnt_d;
  logic signed [pgdd_pkg::QP_W-1:0]   scale_q, scale_d;
  logic signed [pgdd_pkg::QP_W-1:0]   bias_q, bias_d;
  logic                               err_q, err_d;
  logic signed [pgdd_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic signed [pgdd_pkg::ACT_W-1:0]  act_q;
  logic                               last_q;
  logic [pgdd_pkg::CODE_W-1:0]        code_q;
  logic signed [pgdd_pkg::PROD_W-1:0] prod_q;
  logic signed [pgdd_pkg::TERM_W-1:0] term_q;
  logic signed [pgdd_pkg::ACC_W-1:0]  res_q;
  logic                               res_err_q;

  logic [pgdd_pkg::NB_W-1:0]          nb;
  logic [pgdd_pkg::CODE_W-1:0]        code_mask;
  logic [pgdd_pkg::BUF_W-1:0]         word_shifted;
  logic signed [pgdd_pkg::WGT_W-1:0]  weight;
  logic signed [pgdd_pkg::ACC_W:0]    sum_wide;
  logic signed [pgdd_pkg::ACC_W-1:0]  acc_sat;

  // code width register, out-of-range values clamp to 1..16
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_bits_q <= pgdd_pkg::CODE_BITS_RESET;
    end else if (cfg_we_i) begin
      code_bits_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (code_bits_q == '0) begin
      nb = pgdd_pkg::CODE_BITS_MIN;
    end else if (code_bits_q > pgdd_pkg::CODE_BITS_MAX) begin
      nb = pgdd_pkg::CODE_BITS_MAX;
    end else begin
      nb = code_bits_q;
    end
  end

  assign code_mask    = ~({pgdd_pkg::CODE_W{1'b1}} << nb);
  assign word_shifted = pgdd_pkg::BUF_W'(item_i.packed_word) << cnt_q;

  // saturating accumulate of the registered term
  assign sum_wide = (pgdd_pkg::ACC_W + 1)'(acc_q) + (pgdd_pkg::ACC_W + 1)'(term_q);
  always_comb begin
    if (sum_wide[pgdd_pkg::ACC_W] != sum_wide[pgdd_pkg::ACC_W-1]) begin
      acc_sat = sum_wide[pgdd_pkg::ACC_W] ? {1'b1, {(pgdd_pkg::ACC_W-1){1'b0}}}
                                          : {1'b0, {(pgdd_pkg::ACC_W-1){1'b1}}};
    end else begin
      acc_sat = sum_wide[pgdd_pkg::ACC_W-1:0];
    end
  end

  // row state: append, group latch, code extract, accumulate, clear at row end
  always_comb begin
    buf_d   = buf_q;
    cnt_d   = cnt_q;
    scale_d = scale_q;
    bias_d  = bias_q;
    err_d   = err_q;
    acc_d   = acc_q;
    if (cmd_i.load) begin
      if (item_i.word_valid) begin
        if (cnt_q > pgdd_pkg::APPEND_MAX_CNT) begin
          err_d = 1'b1;
        end else begin
          buf_d = buf_q | word_shifted;
          cnt_d = cnt_q + pgdd_pkg::WORD_CNT;
        end
      end
      if (item_i.group_start) begin
        scale_d = item_i.group_scale;
        bias_d  = item_i.group_bias;
      end
    end
    if (cmd_i.extract) begin
      if (cnt_q < pgdd_pkg::CNT_W'(nb)) begin
        err_d = 1'b1;
        buf_d = '0;
        cnt_d = '0;
      end else begin
        buf_d = buf_q >> nb;
        cnt_d = cnt_q - pgdd_pkg::CNT_W'(nb);
      end
    end
    if (cmd_i.acc) begin
      acc_d = acc_sat;
    end
    if (cmd_i.emit) begin
      buf_d   = '0;
      cnt_d   = '0;
      scale_d = '0;
      bias_d  = '0;
      err_d   = 1'b0;
      acc_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q   <= '0;
      cnt_q   <= '0;
      scale_q <= '0;
      bias_q  <= '0;
      err_q   <= 1'b0;
      acc_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      buf_q   <= buf_d;
      cnt_q   <= cnt_d;
      scale_q <= scale_d;
      bias_q  <= bias_d;
      err_q   <= err_d;
      acc_q   <= acc_d;
      if (cmd_i.load) begin
        last_q <= item_i.last_of_row;
      end
    end
  end

  // weight = code * scale + bias, then times the activation
  assign weight = pgdd_pkg::WGT_W'(prod_q) + pgdd_pkg::WGT_W'(bias_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= item_i.act;
    end
    if (cmd_i.extract) begin
      code_q <= buf_q[pgdd_pkg::CODE_W-1:0] & code_mask;
    end
    if (cmd_i.mul) begin
      prod_q <= $signed({1'b0, code_q}) * scale_q;
    end
    if (cmd_i.mac) begin
      term_q <= pgdd_pkg::TERM_W'(act_q) * pgdd_pkg::TERM_W'(weight);
    end
    if (cmd_i.emit) begin
      res_q     <= acc_sat;
      res_err_q <= err_q;
    end
  end

  assign status_o.last      = last_q;
  assign status_o.bit_count = cnt_q;
  assign dot_result_o       = res_q;
  assign row_error_o        = res_err_q;

endmodule

### src/packed_group_dequant_dot_unit.sv
// top level of the packed group dequant dot unit
// depends on pgdd_pkg, pgdd_if, pgdd_ctrl, pgdd_datapath and the defines header
//
//   channel   dir  handshake      payload
//   in_i      in   valid/ready    act, packed_word, word_valid, group_start,
//                                 group_scale, group_bias, last_of_row
//   out_o     out  valid/ready    dot_result, row_error
//   cfg       in   cfg_we_i       cfg_wdata_i (code_bits)
//
// each item passes in turn through transfer, code extract, code*scale multiply,
// activation*weight multiply and accumulate; the controller sequence sets this.
// in_i.ready returns high in the cycle after the accumulate step.
// the result register is separate: a row end only waits in accumulate while a
// previous result is still untaken on out_o.
// reset is asynchronous active low; it clears the row state and sets code_bits to 4.
`timescale 1ns / 1ps
`include "packed_group_dequant_dot_unit_defines.svh"

module packed_group_dequant_dot_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [pgdd_pkg::NB_W-1:0] cfg_wdata_i,
  pgdd_in_if.sink                   in_i,
  pgdd_out_if.source                out_o
);

  pgdd_pkg::cmd_t     cmd;
  pgdd_pkg::status_t  status;
  pgdd_pkg::in_item_t item;

  // gather input payload
  always_comb begin
    item.act         = in_i.act;
    item.packed_word = in_i.packed_word;
    item.word_valid  = in_i.word_valid;
    item.group_start = in_i.group_start;
    item.group_scale = in_i.group_scale;
    item.group_bias  = in_i.group_bias;
    item.last_of_row = in_i.last_of_row;
  end

  pgdd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pgdd_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd),
    .item_i       (item),
    .status_o     (status),
    .dot_result_o (out_o.dot_result),
    .row_error_o  (out_o.row_error)
  );

  // one item in flight: no transfer right after a transfer
  `PGDD_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready)
  // bit buffer never holds more than its 48 bits
  `PGDD_ASSERT_IMP(a_buf_bound, clk_i, rst_ni, 1'b1, status.bit_count <= 6'd48)
  // row end empties the buffer and presents a result
  `PGDD_ASSERT_NXT(a_row_end, clk_i, rst_ni, cmd.emit, (status.bit_count == '0) && out_o.valid)

endmodule
